>>> hw/rtl/imm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imm_pkg: shared definitions for the instruction mask matcher.
// Field widths, command codes, default sizes, the table write command and
// the helper that builds the low-bit mask for a format width.
// ----------------------------------------------------------------------------
package imm_pkg;

   // Fixed widths of the item fields.
   localparam int DATA_W  = 64;
   localparam int WIDTH_W = 7;
   localparam int INDEX_W = 6;

   // Default table geometry.
   localparam int NUM_ENTRIES_DEF = 64;
   localparam int MAX_BITS_DEF    = 64;

   // Priority encoder group size (first encoder stage).
   localparam int GRP_BITS = 3;
   localparam int GRP_SIZE = 1 << GRP_BITS;

   // Command codes of an input item.
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // One table write, issued when a load item is transferred.
   typedef struct packed {
      logic               en;
      logic [INDEX_W-1:0] idx;
      logic               valid;
      logic [WIDTH_W-1:0] width;
      logic [DATA_W-1:0]  mask;
      logic [DATA_W-1:0]  value;
   } imm_wr_type;

   // Ones in the low w bits, with w limited to max_bits.
   function automatic logic [DATA_W-1:0] low_ones(input logic [WIDTH_W-1:0] w,
                                                  input int max_bits);
      logic [DATA_W-1:0] m;
      m = '0;
      for (int b = 0; b < DATA_W; b++) begin
         m[b] = (b < int'(w)) && (b < max_bits);
      end
      return m;
   endfunction

endpackage

>>> hw/rtl/imm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imm_if: valid/ready channels of the instruction mask matcher.
// The request channel carries load and lookup items, the response channel
// carries one result per item.
// ----------------------------------------------------------------------------
interface imm_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [5:0]  entry_index;
   logic        entry_valid;
   logic [6:0]  entry_width;
   logic [63:0] entry_mask;
   logic [63:0] entry_value;
   logic [63:0] payload;
   logic [6:0]  payload_width;

   modport source (output valid, cmd, entry_index, entry_valid, entry_width,
                   entry_mask, entry_value, payload, payload_width,
                   input ready);
   modport sink   (input valid, cmd, entry_index, entry_valid, entry_width,
                   entry_mask, entry_value, payload, payload_width,
                   output ready);
endinterface

interface imm_rsp_if;
   logic       valid;
   logic       ready;
   logic       matched;
   logic [5:0] match_index;
   logic       vliw_fallback;

   modport source (output valid, matched, match_index, vliw_fallback, input ready);
   modport sink   (input valid, matched, match_index, vliw_fallback, output ready);
endinterface

>>> hw/rtl/imm_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imm_table: pattern table with one compare lane per entry.
// Each lane keeps its valid mark, format width, effective mask and masked
// value, and compares them against the incoming lookup in parallel.
// ----------------------------------------------------------------------------
module imm_table #(
   parameter int NUM_ENTRIES = imm_pkg::NUM_ENTRIES_DEF,
   parameter int MAX_BITS    = imm_pkg::MAX_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  imm_pkg::imm_wr_type         wr,
   input  logic [imm_pkg::DATA_W-1:0]  lk_payload,
   input  logic [imm_pkg::WIDTH_W-1:0] lk_width,
   output logic [NUM_ENTRIES-1:0]      hit
);
   import imm_pkg::*;

   // Write data is folded once here: mask limited to the format width, and
   // the value limited to that mask, so a lookup is a single AND and compare.
   logic [DATA_W-1:0] wr_mask_full;
   logic [MAX_BITS-1:0] wr_mask_eff;
   logic [MAX_BITS-1:0] wr_value_eff;

   assign wr_mask_full = wr.mask & low_ones(wr.width, MAX_BITS);
   assign wr_mask_eff  = wr_mask_full[MAX_BITS-1:0];
   assign wr_value_eff = wr.value[MAX_BITS-1:0] & wr_mask_eff;

   for (genvar e = 0; e < NUM_ENTRIES; e++) begin : g_lane
      logic                valid_ff;
      logic [WIDTH_W-1:0]  width_ff;
      logic [MAX_BITS-1:0] mask_ff;
      logic [MAX_BITS-1:0] value_ff;
      logic                sel;

      // A load to an index outside the table selects no lane.
      assign sel = wr.en && (int'(wr.idx) == e);

      // Valid mark is cleared by reset.
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (sel) begin
            valid_ff <= wr.valid;
         end
      end

      // Pattern fields hold no reset value until written.
      always_ff @(posedge clock) begin
         if (sel) begin
            width_ff <= wr.width;
            mask_ff  <= wr_mask_eff;
            value_ff <= wr_value_eff;
         end
      end

      // Lane compare.
      assign hit[e] = valid_ff && (width_ff == lk_width) &&
                      ((lk_payload[MAX_BITS-1:0] & mask_ff) == value_ff);
   end

endmodule

>>> hw/rtl/instruction_mask_matcher.sv
`timescale 1ns / 1ps
// A transferred request passes stage 1, stage 2 and the output register.
// Throughput: one item per cycle; all entries are compared in parallel and
// the lowest hit is found by a two-level registered priority encoder.
// A response stall freezes the whole pipeline; nothing is dropped.
// Reset (synchronous) clears the valid marks, pipeline valids and vliw_ff;
// table patterns are not cleared and matter only once written.
// ----------------------------------------------------------------------------
// instruction_mask_matcher: mask/match instruction decoder.
// Load items write one table entry; lookup items return the lowest-indexed
// valid entry whose width and masked bits match, or, if enabled, a VLIW fallback flag.
// ----------------------------------------------------------------------------
module instruction_mask_matcher #(
   parameter int NUM_ENTRIES = imm_pkg::NUM_ENTRIES_DEF,
   parameter int MAX_BITS    = imm_pkg::MAX_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,
   imm_req_if.sink     req,
   imm_rsp_if.source   rsp
);
   import imm_pkg::*;

   localparam int GRP_N  = (NUM_ENTRIES + GRP_SIZE - 1) / GRP_SIZE;
   localparam int PAD_N  = GRP_N * GRP_SIZE;
   localparam int GRP_W  = (GRP_N > 1) ? $clog2(GRP_N) : 1;
   localparam int IDXF_W = GRP_W + GRP_BITS;
   localparam int EXT_W  = (IDXF_W > INDEX_W) ? IDXF_W : INDEX_W;

   // Configuration register.
   logic vliw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vliw_ff <= 1'b0;
      end else if (csr_we) begin
         vliw_ff <= csr_wdata;
      end
   end

   // The pipeline advances as a whole unless the output register is stalled.
   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || rsp.ready;
   assign req.ready = adv && !reset;

   // Table write on a load transfer.
   imm_wr_type            wr;
   logic [NUM_ENTRIES-1:0] hit;

   always_comb begin
      wr.en    = req.valid && req.ready && (req.cmd == CMD_LOAD);
      wr.idx   = req.entry_index;
      wr.valid = req.entry_valid;
      wr.width = req.entry_width;
      wr.mask  = req.entry_mask;
      wr.value = req.entry_value;
   end

   imm_table #(
      .NUM_ENTRIES (NUM_ENTRIES),
      .MAX_BITS    (MAX_BITS)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .lk_payload (req.payload),
      .lk_width   (req.payload_width),
      .hit        (hit)
   );

   // Stage 1: hit vector of the transferred item.
   logic                   s1_vld_ff;
   logic                   s1_lookup_ff;
   logic [NUM_ENTRIES-1:0] s1_hit_ff;

   // Stage 2: per-group any-hit and lowest offset.
   logic                s2_vld_ff;
   logic                s2_lookup_ff;
   logic [GRP_N-1:0]    s2_any_ff;
   logic [GRP_N-1:0]    s2_any_in;
   logic [GRP_BITS-1:0] s2_low_ff [GRP_N];
   logic [GRP_BITS-1:0] s2_low_in [GRP_N];
   logic [PAD_N-1:0]    hit_pad;

   // Stage 3: output register.
   logic               rsp_matched_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic               rsp_fallback_ff;
   logic               rsp_matched_in;
   logic [INDEX_W-1:0] rsp_index_in;
   logic               rsp_fallback_in;

   // First encoder level: lowest set bit inside each group.
   assign hit_pad = PAD_N'(s1_hit_ff);

   always_comb begin
      for (int g = 0; g < GRP_N; g++) begin
         s2_any_in[g] = |hit_pad[g*GRP_SIZE +: GRP_SIZE];
         s2_low_in[g] = '0;
         for (int b = GRP_SIZE - 1; b >= 0; b--) begin
            if (hit_pad[g*GRP_SIZE + b]) begin
               s2_low_in[g] = GRP_BITS'(b);
            end
         end
      end
   end

   // Second encoder level: lowest group with a hit, then the response fields.
   logic                found;
   logic [GRP_W-1:0]    sel_grp;
   logic [GRP_BITS-1:0] sel_low;
   logic [EXT_W-1:0]    sel_idx;

   always_comb begin
      found   = 1'b0;
      sel_grp = '0;
      sel_low = '0;
      for (int g = GRP_N - 1; g >= 0; g--) begin
         if (s2_any_ff[g]) begin
            found   = 1'b1;
            sel_grp = GRP_W'(g);
            sel_low = s2_low_ff[g];
         end
      end
      sel_idx         = EXT_W'({sel_grp, sel_low});
      rsp_matched_in  = s2_lookup_ff && found;
      rsp_index_in    = rsp_matched_in ? sel_idx[INDEX_W-1:0] : '0;
      rsp_fallback_in = s2_lookup_ff && !found && vliw_ff;
   end

   // Stage valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff    <= req.valid;
         s2_vld_ff    <= s1_vld_ff;
         rsp_valid_ff <= s2_vld_ff;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_lookup_ff    <= (req.cmd == CMD_LOOKUP);
         s1_hit_ff       <= hit;
         s2_lookup_ff    <= s1_lookup_ff;
         s2_any_ff       <= s2_any_in;
         s2_low_ff       <= s2_low_in;
         rsp_matched_ff  <= rsp_matched_in;
         rsp_index_ff    <= rsp_index_in;
         rsp_fallback_ff <= rsp_fallback_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.matched       = rsp_matched_ff;
   assign rsp.match_index   = rsp_index_ff;
   assign rsp.vliw_fallback = rsp_fallback_ff;

endmodule

>>> hw/rtl/imm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imm_checker: port-level checks for the instruction mask matcher.
// Watches the response fields and the stall behavior over time.
// ----------------------------------------------------------------------------
module imm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_matched,
   input logic [5:0] rsp_match_index,
   input logic       rsp_vliw_fallback
);

   // A result never reports a match and a fallback together.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_matched && rsp_vliw_fallback))
      else $error("match and fallback both set");

   // Without a match the index reads as zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_matched) |-> (rsp_match_index == 6'd0))
      else $error("nonzero index without a match");

   // A stalled response freezes the pipeline, so no request is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while response stalled");

   // A stalled response holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_matched) && $stable(rsp_match_index) &&
          $stable(rsp_vliw_fallback)))
      else $error("stalled response changed");

endmodule

bind instruction_mask_matcher imm_checker u_imm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_matched       (rsp.matched),
   .rsp_match_index   (rsp.match_index),
   .rsp_vliw_fallback (rsp.vliw_fallback)
);

>>> tb/imm_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imm_decode_checker: response checker for the instruction mask matcher.
// Keeps its own copy of the pattern table and the VLIW setting, decodes every
// lookup that is transferred into the block, queues an empty result for each
// load, and compares each response, in order, with the oldest outstanding decode.
// ----------------------------------------------------------------------------
module imm_decode_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,
   imm_req_if          req,
   imm_rsp_if          rsp,
   output int unsigned fail_count,
   output int unsigned pending,
   output int unsigned hit_count,
   output int unsigned fallback_count
);
   import imm_pkg::*;

   typedef struct packed {
      logic               matched;
      logic [INDEX_W-1:0] match_index;
      logic               vliw_fallback;
   } decode_type;

   // Shadow of the pattern table and of the configuration register.
   logic               entry_live      [NUM_ENTRIES_DEF];
   logic [WIDTH_W-1:0] entry_fmt_width [NUM_ENTRIES_DEF];
   logic [DATA_W-1:0]  entry_care      [NUM_ENTRIES_DEF];
   logic [DATA_W-1:0]  entry_pattern   [NUM_ENTRIES_DEF];
   logic               fallback_en;

   // Decodes still owed by the block, oldest first.
   decode_type         owed_decodes[$];

   // Bits that a format width covers; widths past the data width cover all.
   function automatic logic [DATA_W-1:0] width_care(input logic [WIDTH_W-1:0] w);
      if (w >= DATA_W) return '1;
      return (64'd1 << w) - 64'd1;
   endfunction

   // Lowest live entry of equal width whose cared-for bits agree wins.
   function automatic decode_type decode_payload(input logic [DATA_W-1:0]  payload,
                                                 input logic [WIDTH_W-1:0] pw);
      decode_type        r;
      logic [DATA_W-1:0] care;
      r = '0;
      for (int i = 0; i < NUM_ENTRIES_DEF; i++) begin
         if (entry_live[i] && entry_fmt_width[i] == pw) begin
            care = entry_care[i] & width_care(entry_fmt_width[i]);
            if ((payload & care) == (entry_pattern[i] & care)) begin
               r.matched     = 1'b1;
               r.match_index = INDEX_W'(i);
               return r;
            end
         end
      end
      r.vliw_fallback = fallback_en;
      return r;
   endfunction

   // Predict on every request transfer, compare on every response transfer.
   always @(posedge clock) begin
      decode_type want;
      if (reset) begin
         for (int i = 0; i < NUM_ENTRIES_DEF; i++) entry_live[i] = 1'b0;
         fallback_en = 1'b0;
         owed_decodes.delete();
         fail_count     = 0;
         hit_count      = 0;
         fallback_count = 0;
      end else begin
         if (csr_we) fallback_en = csr_wdata;

         if (req.valid && req.ready) begin
            if (req.cmd == CMD_LOAD) begin
               entry_live[req.entry_index]      = req.entry_valid;
               entry_fmt_width[req.entry_index] = req.entry_width;
               entry_care[req.entry_index]      = req.entry_mask;
               entry_pattern[req.entry_index]   = req.entry_value;
               want = '0;
            end else begin
               want = decode_payload(req.payload, req.payload_width);
               if (want.matched) hit_count++;
               if (want.vliw_fallback) fallback_count++;
            end
            owed_decodes = {owed_decodes, want};
         end

         if (rsp.valid && rsp.ready) begin
            if (owed_decodes.size() == 0) begin
               $error("response transfer with no outstanding item");
               fail_count++;
            end else begin
               want = owed_decodes.pop_front();
               if (rsp.matched !== want.matched) begin
                  $error("matched: expected %0d, got %0d", want.matched, rsp.matched);
                  fail_count++;
               end
               if (rsp.match_index !== want.match_index) begin
                  $error("match_index: expected %0d, got %0d",
                         want.match_index, rsp.match_index);
                  fail_count++;
               end
               if (rsp.vliw_fallback !== want.vliw_fallback) begin
                  $error("vliw_fallback: expected %0d, got %0d",
                         want.vliw_fallback, rsp.vliw_fallback);
                  fail_count++;
               end
            end
         end
      end
      pending = owed_decodes.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for the instruction mask matcher.
// Loads pattern entries and sends lookups, first a directed set covering the
// width, mask and priority corner cases, then random phases under both VLIW
// settings, with bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module tb;
   import imm_pkg::*;

   localparam int          RANDOM_PHASES   = 3;
   localparam int          PHASE_ITEMS     = 250;
   localparam int unsigned CYCLE_LIMIT     = 200000;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   imm_req_if req_ch ();
   imm_rsp_if rsp_ch ();

   int unsigned fail_count;
   int unsigned pending;
   int unsigned hit_count;
   int unsigned fallback_count;

   int unsigned cycle_count = 0;
   int unsigned n_loads     = 0;
   int unsigned n_lookups   = 0;
   int unsigned burst_left  = 0;

   // What the stimulus has loaded, used only to aim lookups at live entries.
   bit                 ld_written [NUM_ENTRIES_DEF];
   bit                 ld_valid   [NUM_ENTRIES_DEF];
   logic [WIDTH_W-1:0] ld_width   [NUM_ENTRIES_DEF];
   logic [DATA_W-1:0]  ld_mask    [NUM_ENTRIES_DEF];
   logic [DATA_W-1:0]  ld_value   [NUM_ENTRIES_DEF];

   instruction_mask_matcher dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req_ch),
      .rsp       (rsp_ch)
   );

   imm_decode_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .fail_count     (fail_count),
      .pending        (pending),
      .hit_count      (hit_count),
      .fallback_count (fallback_count)
   );

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Run guard.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d decodes outstanding", cycle_count, pending);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Response side: the stall pattern changes mode every so often.
   int unsigned stall_mode = 0;
   int unsigned mode_left  = 0;
   int unsigned stall_left = 0;

   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(30, 150);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ch.ready <= mode_left[0];
         default: begin
            if (stall_left != 0) begin
               stall_left--;
               rsp_ch.ready <= 1'b0;
            end else begin
               rsp_ch.ready <= 1'b1;
               if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
            end
         end
      endcase
   end

   function automatic logic [DATA_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Widths cluster on a few common formats so that entries compete.
   function automatic logic [WIDTH_W-1:0] pick_width();
      case ($urandom_range(0, 9))
         6:       return 7'd1;
         7:       return 7'd0;
         8:       return WIDTH_W'($urandom_range(65, 127));
         9:       return WIDTH_W'($urandom_range(1, 64));
         default: return WIDTH_W'(8 << $urandom_range(0, 3));
      endcase
   endfunction

   // Drive one set of request signals; called on a falling edge.
   task automatic put_item(input logic v, input logic cmd, input logic [INDEX_W-1:0] idx,
                           input logic ev, input logic [WIDTH_W-1:0] ew,
                           input logic [DATA_W-1:0] em, input logic [DATA_W-1:0] eval,
                           input logic [DATA_W-1:0] p, input logic [WIDTH_W-1:0] pw);
      req_ch.valid         <= v;
      req_ch.cmd           <= cmd;
      req_ch.entry_index   <= idx;
      req_ch.entry_valid   <= ev;
      req_ch.entry_width   <= ew;
      req_ch.entry_mask    <= em;
      req_ch.entry_value   <= eval;
      req_ch.payload       <= p;
      req_ch.payload_width <= pw;
   endtask

   // Present one item and hold it until the transfer.
   task automatic send_item(input logic cmd, input logic [INDEX_W-1:0] idx,
                            input logic ev, input logic [WIDTH_W-1:0] ew,
                            input logic [DATA_W-1:0] em, input logic [DATA_W-1:0] eval,
                            input logic [DATA_W-1:0] p, input logic [WIDTH_W-1:0] pw);
      @(negedge clock);
      put_item(1'b1, cmd, idx, ev, ew, em, eval, p, pw);
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Drops valid on the request side, with junk on the payload.
   task automatic idle_cycle();
      @(negedge clock);
      put_item(1'b0, 1'($urandom), INDEX_W'($urandom), 1'($urandom), WIDTH_W'($urandom),
               rand64(), rand64(), rand64(), WIDTH_W'($urandom));
   endtask

   task automatic load(input logic [INDEX_W-1:0] idx, input logic ev,
                       input logic [WIDTH_W-1:0] ew, input logic [DATA_W-1:0] em,
                       input logic [DATA_W-1:0] eval);
      send_item(CMD_LOAD, idx, ev, ew, em, eval, rand64(), WIDTH_W'($urandom));
      ld_written[idx] = 1'b1;
      ld_valid[idx]   = ev;
      ld_width[idx]   = ew;
      ld_mask[idx]    = em;
      ld_value[idx]   = eval;
      n_loads++;
   endtask

   task automatic lookup(input logic [DATA_W-1:0] p, input logic [WIDTH_W-1:0] pw);
      send_item(CMD_LOOKUP, INDEX_W'($urandom), 1'($urandom), WIDTH_W'($urandom),
                rand64(), rand64(), p, pw);
      n_lookups++;
   endtask

   // Bursts of random length separated by random gaps.
   task automatic pace();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 8)) idle_cycle();
      end
      burst_left--;
   endtask

   // Wait until every response has come back, then let the pipeline settle.
   task automatic drain();
      idle_cycle();
      while (pending != 0) @(negedge clock);
      repeat (4) idle_cycle();
   endtask

   task automatic set_vliw(input logic v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
      csr_wdata <= 1'($urandom);
   endtask

   // One random item: mostly lookups, many aimed at live entries, plus loads and noise.
   task automatic random_item();
      logic [INDEX_W-1:0] idx;
      logic [DATA_W-1:0]  m;
      logic [DATA_W-1:0]  p;
      bit                 found;
      found = 1'b0;
      if ($urandom_range(0, 99) < 30) begin
         case ($urandom_range(0, 5))
            0:       m = rand64() & rand64();
            1:       m = rand64() | rand64();
            2:       m = '1;
            3:       m = '0;
            default: m = rand64();
         endcase
         load(INDEX_W'($urandom), ($urandom_range(0, 6) != 0), pick_width(), m, rand64());
      end else if ($urandom_range(0, 99) < 65) begin
         for (int t = 0; t < 8 && !found; t++) begin
            idx = INDEX_W'($urandom);
            found = ld_written[idx] && ld_valid[idx];
         end
         if (found) begin
            p = (ld_value[idx] & ld_mask[idx]) | (rand64() & ~ld_mask[idx]);
            // Near misses: one flipped bit.
            if ($urandom_range(0, 3) == 0) p[$urandom_range(0, DATA_W - 1)] ^= 1'b1;
            lookup(p, ld_width[idx]);
         end else begin
            lookup(rand64(), pick_width());
         end
      end else if ($urandom_range(0, 1) == 0) begin
         lookup(rand64(), pick_width());
      end else begin
         lookup(rand64(), WIDTH_W'($urandom_range(0, 127)));
      end
   endtask

   // Stimulus and verdict.
   initial begin
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_wdata = 1'b0;
      rsp_ch.ready = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_LOAD;
      req_ch.entry_index = '0;
      req_ch.entry_valid = 1'b0;
      req_ch.entry_width = '0;
      req_ch.entry_mask = '0;
      req_ch.entry_value = '0;
      req_ch.payload = '0;
      req_ch.payload_width = '0;
      for (int i = 0; i < NUM_ENTRIES_DEF; i++) ld_written[i] = 1'b0;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes of index and width, masks past the width, odd widths,
      // invalid entries and priority between overlapping patterns.
      set_vliw(1'b0);
      load(6'd0, 1'b1, 7'd64, '1, 64'hDEAD_BEEF_0123_4567);
      load(6'd63, 1'b1, 7'd1, 64'h1, 64'h1);
      load(6'd1, 1'b1, 7'd8, 64'hFFFF_FFFF_FFFF_FF0F, 64'hFFFF_FFFF_FFFF_FF05);
      load(6'd2, 1'b1, 7'd0, '1, rand64());
      load(6'd3, 1'b1, 7'd127, 64'hFF00, 64'h1200);
      load(6'd4, 1'b0, 7'd16, '0, '0);
      load(6'd5, 1'b1, 7'd16, 64'h00FF, 64'h0042);
      load(6'd6, 1'b1, 7'd16, 64'h000F, 64'h0002);
      lookup(64'hDEAD_BEEF_0123_4567, 7'd64);
      lookup(~64'hDEAD_BEEF_0123_4567, 7'd64);
      lookup(64'h1, 7'd1);
      lookup('1, 7'd1);
      lookup(64'h0, 7'd1);
      lookup(64'hA5, 7'd8);
      lookup(rand64(), 7'd0);
      lookup(64'hABCD_12FF, 7'd127);
      lookup(64'h42, 7'd16);
      lookup(64'h1232, 7'd16);
      lookup(64'h0, 7'd16);
      load(6'd5, 1'b0, 7'd16, 64'h00FF, 64'h0042);
      lookup(64'h42, 7'd16);
      drain();

      // Directed: misses with the fallback enabled, followed by hits.
      set_vliw(1'b1);
      lookup(64'h0, 7'd16);
      lookup(rand64(), 7'd65);
      lookup(~64'hDEAD_BEEF_0123_4567, 7'd64);
      load(6'd0, 1'b1, 7'd64, '0, rand64());
      lookup(rand64(), 7'd64);
      lookup(64'h5, 7'd8);
      drain();

      // Random phases alternating the VLIW setting.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         set_vliw(ph % 2 == 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pace();
            random_item();
         end
         drain();
      end
      repeat (8) @(negedge clock);

      $display("covered %0d loads and %0d lookups under both VLIW settings",
               n_loads, n_lookups);
      $display("lookups that hit: %0d, that fell back to VLIW: %0d, mismatches: %0d",
               hit_count, fallback_count, fail_count);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/imm_pkg.sv
hw/rtl/imm_if.sv
hw/rtl/imm_table.sv
hw/rtl/instruction_mask_matcher.sv
hw/rtl/imm_checker.sv
tb/imm_decode_checker.sv
tb/tb.sv
